// ===== design/b64fr_pkg.sv =====
// Shared types, constants and character helpers for the base64 frame receiver.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package b64fr_pkg;

  localparam int PAYLOAD_CHARS_DEF = 64;
  localparam int CNT_W             = 7;

  localparam logic [7:0]       SYNC_BYTE = 8'hAA;
  localparam logic [7:0]       EOF_BYTE  = 8'hA5;
  localparam logic [7:0]       DATA_TYPE = 8'h05;
  localparam logic [7:0]       PAD_CHAR  = 8'h3D;
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;
  localparam logic [3:0]       NAME_LAST = 4'd8;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_NAME = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    DROP_NONE  = 3'd0,
    DROP_SHORT = 3'd1,
    DROP_LONG  = 3'd2,
    DROP_BAD   = 3'd3,
    DROP_TYPE  = 3'd4
  } drop_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_RD,
    S_CAP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic rd;
    logic cap;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic res_now;
    logic dec_now;
    logic slot_free;
    logic grp_done;
    logic grp_end;
    logic final_byte;
  } sts_t;

  // Characters of the name request text, in order.
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    begin
      unique case (idx)
        4'd0:    c = 8'h41;
        4'd1:    c = 8'h54;
        4'd2:    c = 8'h2B;
        4'd3:    c = 8'h4E;
        4'd4:    c = 8'h41;
        4'd5:    c = 8'h4D;
        4'd6:    c = 8'h45;
        4'd7:    c = 8'h3F;
        4'd8:    c = 8'h0D;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  function automatic logic is_b64(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F;
  endfunction

  // Six-bit value of an alphabet character; padding and others give zero.
  function automatic logic [5:0] sextet(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
        v = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        v = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
        v = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
        v = 8'd62;
      end else if (c == 8'h2F) begin
        v = 8'd63;
      end
      return v[5:0];
    end
  endfunction

endpackage

// ===== design/b64fr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module b64fr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/b64fr_ctrl.sv =====
// Controller FSM of the base64 frame receiver: sequences byte intake,
// result push and the per-character decode loop. Depends on b64fr_pkg.
`timescale 1ns / 1ps

module b64fr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  b64fr_pkg::sts_t sts,
  output b64fr_pkg::cmd_t cmd
);

  b64fr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b64fr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b64fr_pkg::S_IDLE: begin
        if (in_valid) begin
          if (sts.res_now) begin
            state_nxt = b64fr_pkg::S_PUSH;
          end else if (sts.dec_now) begin
            state_nxt = b64fr_pkg::S_RD;
          end
        end
      end
      b64fr_pkg::S_PUSH: begin
        if (sts.slot_free) begin
          state_nxt = b64fr_pkg::S_IDLE;
        end
      end
      b64fr_pkg::S_RD: begin
        state_nxt = b64fr_pkg::S_CAP;
      end
      b64fr_pkg::S_CAP: begin
        state_nxt = sts.grp_done ? b64fr_pkg::S_EMIT : b64fr_pkg::S_RD;
      end
      b64fr_pkg::S_EMIT: begin
        if (sts.slot_free && sts.grp_end) begin
          state_nxt = sts.final_byte ? b64fr_pkg::S_IDLE : b64fr_pkg::S_RD;
        end
      end
      default: begin
        state_nxt = b64fr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state_r == b64fr_pkg::S_IDLE);
    cmd.accept = (state_r == b64fr_pkg::S_IDLE) && in_valid;
    cmd.push   = (state_r == b64fr_pkg::S_PUSH) && sts.slot_free;
    cmd.rd     = (state_r == b64fr_pkg::S_RD);
    cmd.cap    = (state_r == b64fr_pkg::S_CAP);
    cmd.emit   = (state_r == b64fr_pkg::S_EMIT) && sts.slot_free;
  end

endmodule

// ===== design/b64fr_datapath.sv =====
// Datapath of the base64 frame receiver: name matcher, framer state, payload
// store, running validity check, decode accumulator and output register.
// Depends on b64fr_pkg and b64fr_ram.
`timescale 1ns / 1ps

module b64fr_datapath #(
  parameter int PAYLOAD_CHARS = b64fr_pkg::PAYLOAD_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_rx_byte,
  input  logic                         cfg_we,
  input  logic [b64fr_pkg::CNT_W-1:0]  cfg_data,
  input  b64fr_pkg::cmd_t              cmd,
  output b64fr_pkg::sts_t              sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_data_byte,
  output logic [2:0]                   out_drop_code,
  output logic                         out_last
);

  localparam int AW = $clog2(PAYLOAD_CHARS);
  localparam int CW = b64fr_pkg::CNT_W;
  localparam logic [CW-1:0] PAY_MAX = CW'(PAYLOAD_CHARS);

  // Configuration
  logic [CW-1:0] cap_r;

  // Matcher and framer
  logic [3:0]    match_idx_r, match_idx_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    type_r, type_nxt;
  logic          ovf_r, ovf_nxt;
  logic          bad_r, bad_nxt;
  logic [7:0]    prev1_r, prev1_nxt;
  logic [7:0]    prev2_r, prev2_nxt;

  // Pending single result, decode loop, output register
  b64fr_pkg::kind_t      pend_kind_r;
  b64fr_pkg::drop_code_t pend_code_r;
  logic [CW-1:0]         n_r;
  logic [1:0]            pad_r;
  logic [CW-1:0]         rd_idx_r;
  logic [23:0]           acc_r;
  logic [1:0]            bsel_r;
  logic                  out_valid_r;
  b64fr_pkg::kind_t      out_kind_r;
  logic [7:0]            out_data_r;
  b64fr_pkg::drop_code_t out_code_r;
  logic                  out_last_r;

  logic                  match_hit;
  logic                  is_sync, is_eof, closing;
  logic [CW-1:0]         chars, pos;
  logic [1:0]            pad_c;
  logic                  tail_ok, b64_ok;
  b64fr_pkg::drop_code_t close_code;
  logic                  store_ok;
  logic [7:0]            rdata;
  logic                  final_grp;
  logic [1:0]            last_bsel;
  logic [7:0]            emit_byte;

  // Name matcher: a mismatching byte always returns to the start
  always_comb begin
    match_hit     = 1'b0;
    match_idx_nxt = 4'd0;
    if (match_idx_r == 4'd0 && in_rx_byte == b64fr_pkg::name_char(4'd0)) begin
      match_idx_nxt = 4'd1;
    end else if (match_idx_r != 4'd0 && match_idx_r <= b64fr_pkg::NAME_LAST &&
                 in_rx_byte == b64fr_pkg::name_char(match_idx_r)) begin
      if (match_idx_r == b64fr_pkg::NAME_LAST) begin
        match_hit = 1'b1;
      end else begin
        match_idx_nxt = match_idx_r + 4'd1;
      end
    end
  end

  assign is_sync  = (in_rx_byte == b64fr_pkg::SYNC_BYTE);
  assign is_eof   = (in_rx_byte == b64fr_pkg::EOF_BYTE);
  assign closing  = !match_hit && !is_sync && in_frame_r && is_eof;
  assign chars    = (count_r == '0) ? '0 : count_r - CW'(1);
  assign pos      = count_r - CW'(1);
  assign store_ok = (pos < PAY_MAX);

  // The last two characters settle the padding; everything older is in bad_r
  always_comb begin
    pad_c = 2'd0;
    if (prev1_r == b64fr_pkg::PAD_CHAR) begin
      pad_c   = (prev2_r == b64fr_pkg::PAD_CHAR) ? 2'd2 : 2'd1;
      tail_ok = (prev2_r == b64fr_pkg::PAD_CHAR) || b64fr_pkg::is_b64(prev2_r);
    end else begin
      tail_ok = b64fr_pkg::is_b64(prev1_r) && b64fr_pkg::is_b64(prev2_r);
    end
  end

  assign b64_ok = !bad_r && (chars[1:0] == 2'b00) && tail_ok;

  always_comb begin
    priority if (chars == '0) begin
      close_code = b64fr_pkg::DROP_SHORT;
    end else if (ovf_r || chars > cap_r || chars > PAY_MAX) begin
      close_code = b64fr_pkg::DROP_LONG;
    end else if (type_r != b64fr_pkg::DATA_TYPE) begin
      close_code = b64fr_pkg::DROP_TYPE;
    end else if (!b64_ok) begin
      close_code = b64fr_pkg::DROP_BAD;
    end else begin
      close_code = b64fr_pkg::DROP_NONE;
    end
  end

  assign sts.res_now = match_hit || (closing && close_code != b64fr_pkg::DROP_NONE);
  assign sts.dec_now = closing && close_code == b64fr_pkg::DROP_NONE;

  // Framer next state
  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    type_nxt     = type_r;
    ovf_nxt      = ovf_r;
    bad_nxt      = bad_r;
    prev1_nxt    = prev1_r;
    prev2_nxt    = prev2_r;
    if (match_hit || is_sync || closing) begin
      in_frame_nxt = !match_hit && is_sync;
      count_nxt    = '0;
      type_nxt     = 8'h00;
      ovf_nxt      = 1'b0;
      bad_nxt      = 1'b0;
    end else if (in_frame_r) begin
      if (count_r == '0) begin
        type_nxt  = in_rx_byte;
        count_nxt = CW'(1);
      end else begin
        if (store_ok) begin
          prev1_nxt = in_rx_byte;
          prev2_nxt = prev1_r;
          if (count_r >= CW'(3)) begin
            bad_nxt = bad_r || !b64fr_pkg::is_b64(prev2_r);
          end
        end else begin
          ovf_nxt = 1'b1;
        end
        if (count_r != b64fr_pkg::CNT_MAX) begin
          count_nxt = count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= b64fr_pkg::CAP_RESET;
      match_idx_r <= 4'd0;
      in_frame_r  <= 1'b0;
      count_r     <= '0;
      type_r      <= 8'h00;
      ovf_r       <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (cmd.accept) begin
        match_idx_r <= match_idx_nxt;
        in_frame_r  <= in_frame_nxt;
        count_r     <= count_nxt;
        type_r      <= type_nxt;
        ovf_r       <= ovf_nxt;
        bad_r       <= bad_nxt;
      end
    end
  end

  // Payload registers: last characters, pending result, decode setup
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prev1_r     <= prev1_nxt;
      prev2_r     <= prev2_nxt;
      pend_kind_r <= match_hit ? b64fr_pkg::KIND_NAME : b64fr_pkg::KIND_DROP;
      pend_code_r <= match_hit ? b64fr_pkg::DROP_NONE : close_code;
      n_r         <= chars;
      pad_r       <= pad_c;
      rd_idx_r    <= '0;
    end else if (cmd.cap) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
    if (cmd.cap) begin
      acc_r  <= {acc_r[17:0], b64fr_pkg::sextet(rdata)};
      bsel_r <= 2'd0;
    end else if (cmd.emit) begin
      bsel_r <= bsel_r + 2'd1;
    end
  end

  b64fr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_CHARS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && in_frame_r && !match_hit && !is_sync && !is_eof &&
            count_r != '0 && store_ok),
    .waddr (pos[AW-1:0]),
    .wdata (in_rx_byte),
    .re    (cmd.rd),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // Decode group bookkeeping: rd_idx_r points past the group being emitted
  assign sts.grp_done   = (rd_idx_r[1:0] == 2'b11);
  assign final_grp      = (rd_idx_r == n_r);
  assign last_bsel      = final_grp ? 2'd2 - pad_r : 2'd2;
  assign sts.grp_end    = (bsel_r == last_bsel);
  assign sts.final_byte = final_grp && sts.grp_end;

  always_comb begin
    unique case (bsel_r)
      2'd0:    emit_byte = acc_r[23:16];
      2'd1:    emit_byte = acc_r[15:8];
      default: emit_byte = acc_r[7:0];
    endcase
  end

  // Output register
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_kind_r <= pend_kind_r;
      out_data_r <= 8'h00;
      out_code_r <= pend_code_r;
      out_last_r <= 1'b1;
    end else if (cmd.emit) begin
      out_kind_r <= b64fr_pkg::KIND_DATA;
      out_data_r <= emit_byte;
      out_code_r <= b64fr_pkg::DROP_NONE;
      out_last_r <= sts.final_byte;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_r;
  assign out_drop_code = out_code_r;
  assign out_last      = out_last_r;

endmodule

// ===== design/base64_frame_receiver_unit.sv =====
// Base64 frame receiver top level: controller plus datapath. A byte that gives no result
// leaves the controller in idle; a name request or drop is held pending in the push state
// until the output register is free, and the intake stays closed meanwhile. A data frame
// is decoded by reading and then capturing each stored character and emitting each decoded
// byte, limited by the single read port of the payload store and out_ready.
// Reset (rst_n low, synchronous) clears framer, matcher, output valid and sets capacity 64;
// the payload store is not cleared and needs no clearing pass. Depends on b64fr_pkg.
`timescale 1ns / 1ps

module base64_frame_receiver_unit #(
  parameter int PAYLOAD_CHARS = b64fr_pkg::PAYLOAD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // received byte channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // capacity register write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_capacity_chars,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_drop_code,
  output logic       out_last
);

  b64fr_pkg::cmd_t cmd;
  b64fr_pkg::sts_t sts;

  // The capacity register takes a write in any cycle; the user must issue writes only
  // while no frame close is in flight, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // Controller: accept bytes in idle, hold until a pending result is taken,
  // and step the decode loop (read, capture, emit) over the stored characters.
  b64fr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: matcher, framer, payload store, validity tracking, decoder and
  // the output register that parts the result channel from the intake.
  b64fr_datapath #(
    .PAYLOAD_CHARS (PAYLOAD_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_rx_byte    (in_rx_byte),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_capacity_chars),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_drop_code (out_drop_code),
    .out_last      (out_last)
  );

  // A name request or a drop is always the only result of its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != b64fr_pkg::KIND_DATA |-> out_last)
    else $error("single result transaction without last");

  // Only decoded bytes carry data, only drops carry a code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != b64fr_pkg::KIND_DATA |-> out_data_byte == 8'h00)
    else $error("non-data transaction with nonzero data byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != b64fr_pkg::KIND_DROP |-> out_drop_code == b64fr_pkg::DROP_NONE)
    else $error("drop code on a non-drop transaction");

  // Intake stays closed while the decode loop or a pending result is active.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.cap || cmd.emit || cmd.push) |-> !in_ready)
    else $error("intake open during result generation");

endmodule
